FILE: rtl/zpk_transfer_function_eval_core_defines.svh
// Assertion helpers for the RTL file that checks itself.
// Each macro expects clk and rst_n in scope.
`ifndef ZPK_TRANSFER_FUNCTION_EVAL_CORE_DEFINES_SVH
`define ZPK_TRANSFER_FUNCTION_EVAL_CORE_DEFINES_SVH

// Same-cycle implication.
`define ZPK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ZPK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/zpk_pkg.sv
package zpk_pkg;

    localparam int MaxOrder  = 8;
    localparam int StepW     = $clog2(MaxOrder + 1);
    localparam int SlotW     = 3;
    localparam int ValW      = 24;
    localparam int DiffW     = ValW + 1;
    localparam int CntW      = 4;
    localparam int CfgIdxW   = 3;
    localparam int MantW     = 31;
    localparam int ProdW     = 2 * MantW;
    localparam int NormW     = 64;
    localparam int ExpW      = 16;
    localparam int DivW      = 30;
    localparam int QuoW      = 33;
    localparam int OutW      = 32;
    localparam int DivSteps  = 32;
    localparam int DivCntW   = $clog2(DivSteps + 1);
    localparam int FracBits  = 20;

    localparam logic signed [MantW-1:0] MantInit = MantW'(64'd1 << 29);
    localparam logic signed [ExpW-1:0]  ExpInit  = -16'sd29;
    localparam logic signed [ValW-1:0]  GainInit = 24'sd1048576;

    localparam logic [1:0] MODE_LOAD_ZERO = 2'd0;
    localparam logic [1:0] MODE_LOAD_POLE = 2'd1;
    localparam logic [1:0] MODE_EVAL      = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_GAIN_RE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_IM    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_IS_DIGITAL = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ZERO_COUNT = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_POLE_COUNT = 3'd4;

    typedef struct packed {
        logic signed [ValW-1:0] re;
        logic signed [ValW-1:0] im;
    } cplx_val_t;

endpackage

FILE: rtl/zpk_cell.sv
// One store slot: a zero and a pole; rotate toward the head when shifting.
module zpk_cell import zpk_pkg::*;
(
    input  logic      clk,
    input  logic      zero_we,
    input  logic      pole_we,
    input  cplx_val_t wdata,
    input  logic      shift_en,
    input  cplx_val_t zero_in,
    input  cplx_val_t pole_in,
    output cplx_val_t zero_out,
    output cplx_val_t pole_out
);

    cplx_val_t zero_reg;
    cplx_val_t pole_reg;

    always_ff @(posedge clk)
    begin
        if (zero_we)
        begin
            zero_reg <= wdata;
        end
        else if (shift_en)
        begin
            zero_reg <= zero_in;
        end
        if (pole_we)
        begin
            pole_reg <= wdata;
        end
        else if (shift_en)
        begin
            pole_reg <= pole_in;
        end
    end

    assign zero_out = zero_reg;
    assign pole_out = pole_reg;

endmodule

FILE: rtl/zpk_div.sv
// Restoring divider for both quotient parts: one integer bit, then one
// fraction bit per cycle.
module zpk_div import zpk_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DivW-1:0] n_re,
    input  logic [DivW-1:0] n_im,
    input  logic [DivW-1:0] d,
    output logic            done,
    output logic [QuoW-1:0] q_re,
    output logic [QuoW-1:0] q_im
);

    logic [DivW-1:0]    d_reg;
    logic [DivW-1:0]    rem_re_reg;
    logic [DivW-1:0]    rem_im_reg;
    logic [QuoW-1:0]    q_re_reg;
    logic [QuoW-1:0]    q_im_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               done_reg;
    logic [DivW:0]      t_re;
    logic [DivW:0]      t_im;
    logic               ge_re;
    logic               ge_im;

    assign t_re  = {rem_re_reg, 1'b0};
    assign t_im  = {rem_im_reg, 1'b0};
    assign ge_re = t_re >= {1'b0, d_reg};
    assign ge_im = t_im >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DivCntW'(DivSteps);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DivCntW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg      <= d;
            rem_re_reg <= (n_re >= d) ? n_re - d : n_re;
            rem_im_reg <= (n_im >= d) ? n_im - d : n_im;
            q_re_reg   <= QuoW'(n_re >= d);
            q_im_reg   <= QuoW'(n_im >= d);
        end
        else if (cnt_reg != '0)
        begin
            rem_re_reg <= ge_re ? DivW'(t_re - {1'b0, d_reg}) : t_re[DivW-1:0];
            rem_im_reg <= ge_im ? DivW'(t_im - {1'b0, d_reg}) : t_im[DivW-1:0];
            q_re_reg   <= {q_re_reg[QuoW-2:0], ge_re};
            q_im_reg   <= {q_im_reg[QuoW-2:0], ge_im};
        end
    end

    assign done = done_reg;
    assign q_re = q_re_reg;
    assign q_im = q_im_reg;

endmodule

FILE: rtl/zpk_transfer_function_eval_core.sv
// Evaluates a zero-pole-gain transfer function at a complex point. A load item
// (mode 0 zero, mode 1 pole) writes one slot and gives no result. An evaluate
// item (mode 2) raises busy until its one result comes out; the result is
// shown for exactly one cycle with done high and the receiver cannot stall it,
// so sample it on that edge. Evaluation walks the row of MaxOrder store cells
// twice (numerator, then denominator), rotating one slot a cycle while no factor
// pass is under way; each factor that is used costs one pass through the shared
// complex multiplier: select, multiply, sum, then normalize. The quotient adds
// two multiplier passes and a pass through the divider. A zero point in digital
// mode answers in the cycle after it is taken, without raising busy. Zeros and
// poles are undefined until loaded; the user must write configuration only
// while idle, and the block itself does not enforce it.
`include "zpk_transfer_function_eval_core_defines.svh"
module zpk_transfer_function_eval_core import zpk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             mode,
    input  logic [SlotW-1:0]       slot,
    input  logic signed [ValW-1:0] value_re,
    input  logic signed [ValW-1:0] value_im,
    input  logic                   cfg_we,
    input  logic [CfgIdxW-1:0]     cfg_addr,
    input  logic [ValW-1:0]        cfg_wdata,
    output logic                   done,
    output logic signed [OutW-1:0] response_re,
    output logic signed [OutW-1:0] response_im,
    output logic                   saturated,
    output logic                   divide_error
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ROOT  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_SUM   = 8'b0000_1000,
        ST_NORM  = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    // What the multiplier pass currently computes.
    typedef enum logic [2:0] {
        PH_NUM  = 3'd0,
        PH_GAIN = 3'd1,
        PH_DEN  = 3'd2,
        PH_D    = 3'd3,
        PH_Q    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [OutW-1:0] val;
        logic            sat;
    } scaled_t;

    // Scale one quotient magnitude to Q16.16, clamp, and apply the sign.
    function automatic scaled_t scale_part(input logic neg, input logic [QuoW-1:0] q,
                                           input logic signed [ExpW-1:0] sh);
        logic [QuoW-1:0] lim;
        logic [QuoW-1:0] qs;
        logic [ExpW-1:0] amt;
        scaled_t         res;
        lim     = neg ? 33'h080000000 : 33'h07fffffff;
        res.sat = 1'b0;
        amt     = ExpW'(-sh);
        qs      = q;
        if (sh < 0)
        begin
            qs = (amt >= ExpW'(QuoW)) ? '0 : (q >> amt);
        end
        else if (sh > 0)
        begin
            if ((q != '0) && ((sh >= 16'sd31) || (q > (lim >> sh))))
            begin
                qs      = lim;
                res.sat = 1'b1;
            end
            else
            begin
                qs = q << sh;
            end
        end
        if (qs > lim)
        begin
            qs      = lim;
            res.sat = 1'b1;
        end
        res.val = neg ? OutW'(-qs[OutW-1:0]) : qs[OutW-1:0];
        return res;
    endfunction

    // Configuration
    logic signed [ValW-1:0] gain_re_reg;
    logic signed [ValW-1:0] gain_im_reg;
    logic                   is_digital_reg;
    logic [CntW-1:0]        zero_count_reg;
    logic [CntW-1:0]        pole_count_reg;

    // Control
    state_t           state_reg;
    phase_t           phase_reg;
    logic [StepW-1:0] step_reg;

    // Datapath
    logic signed [ValW-1:0]  pt_re_reg;
    logic signed [ValW-1:0]  pt_im_reg;
    logic signed [MantW-1:0] num_re_reg;
    logic signed [MantW-1:0] num_im_reg;
    logic signed [ExpW-1:0]  num_e_reg;
    logic signed [MantW-1:0] den_re_reg;
    logic signed [MantW-1:0] den_im_reg;
    logic signed [ExpW-1:0]  den_e_reg;
    logic signed [MantW-1:0] fac_re_reg;
    logic signed [MantW-1:0] fac_im_reg;
    logic signed [ProdW-1:0] prod_reg [4];
    logic signed [NormW-1:0] nrm_re_reg;
    logic signed [NormW-1:0] nrm_im_reg;
    logic signed [ExpW-1:0]  nrm_e_reg;
    logic [DivW-1:0]         d_reg;
    logic signed [ExpW-1:0]  ed_reg;
    logic                    nq_neg_re_reg;
    logic                    nq_neg_im_reg;
    logic signed [ExpW-1:0]  nq_e_reg;

    // Result
    logic                   done_reg;
    logic signed [OutW-1:0] response_re_reg;
    logic signed [OutW-1:0] response_im_reg;
    logic                   saturated_reg;
    logic                   divide_error_reg;

    logic accept;
    logic shift_en;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Store cells: rotate toward cell 0, which feeds the multiplier.
    cplx_val_t zero_q [MaxOrder];
    cplx_val_t pole_q [MaxOrder];
    cplx_val_t wdata;

    assign wdata.re = value_re;
    assign wdata.im = value_im;

    for (genvar k = 0; k < MaxOrder; k++)
    begin : g_cell
        zpk_cell u_cell
        (
            .clk      (clk),
            .zero_we  (accept && (mode == MODE_LOAD_ZERO) && (int'(slot) == k)),
            .pole_we  (accept && (mode == MODE_LOAD_POLE) && (int'(slot) == k)),
            .wdata    (wdata),
            .shift_en (shift_en),
            .zero_in  (zero_q[(k + 1) % MaxOrder]),
            .pole_in  (pole_q[(k + 1) % MaxOrder]),
            .zero_out (zero_q[k]),
            .pole_out (pole_q[k])
        );
    end

    // Root step selection
    logic [StepW-1:0] nz;
    logic [StepW-1:0] np;
    logic             pass_den;
    logic             use_store;
    logic             use_point;
    logic             last_step;
    cplx_val_t        head;

    assign nz = (int'(zero_count_reg) > MaxOrder) ? StepW'(MaxOrder) : StepW'(zero_count_reg);
    assign np = (int'(pole_count_reg) > MaxOrder) ? StepW'(MaxOrder) : StepW'(pole_count_reg);
    assign pass_den  = (phase_reg == PH_DEN);
    assign head      = pass_den ? pole_q[0] : zero_q[0];
    assign use_store = pass_den ? (step_reg < np) : (step_reg < nz);
    assign use_point = is_digital_reg && (pass_den ? (step_reg < nz) : (step_reg < np));
    assign last_step = (step_reg == StepW'(MaxOrder));
    assign shift_en  = (state_reg == ST_ROOT) && !last_step;

    // Multiplier operands
    logic signed [MantW-1:0] a_re;
    logic signed [MantW-1:0] a_im;
    logic signed [MantW-1:0] b_re;
    logic signed [MantW-1:0] b_im;
    logic signed [ExpW-1:0]  a_e;
    logic                    a_is_den;
    logic                    b_is_den;

    assign a_is_den = (phase_reg == PH_DEN) || (phase_reg == PH_D);
    assign b_is_den = (phase_reg == PH_Q) || (phase_reg == PH_D);
    assign a_re = a_is_den ? den_re_reg : num_re_reg;
    assign a_im = a_is_den ? den_im_reg : num_im_reg;
    assign a_e  = a_is_den ? den_e_reg : num_e_reg;
    assign b_re = b_is_den ? den_re_reg : fac_re_reg;
    assign b_im = b_is_den ? den_im_reg : fac_im_reg;

    // Normalizer: bring the larger part magnitude into [2^29, 2^30).
    logic [NormW-1:0] abs_re;
    logic [NormW-1:0] abs_im;
    logic [NormW-1:0] mag;
    logic             nrm_zero;
    logic             big4;
    logic             big1;
    logic             small4;
    logic             small1;
    logic             nrm_done;

    assign abs_re   = (nrm_re_reg < 0) ? NormW'(-nrm_re_reg) : NormW'(nrm_re_reg);
    assign abs_im   = (nrm_im_reg < 0) ? NormW'(-nrm_im_reg) : NormW'(nrm_im_reg);
    assign mag      = (abs_re > abs_im) ? abs_re : abs_im;
    assign nrm_zero = (nrm_re_reg == '0) && (nrm_im_reg == '0);
    assign big4     = (mag[NormW-1:34] != '0);
    assign big1     = (mag[NormW-1:30] != '0);
    assign small4   = (mag[NormW-1:26] == '0);
    assign small1   = (mag[NormW-1:29] == '0);
    assign nrm_done = nrm_zero || (!big1 && !small1);

    // Divider
    logic            div_start;
    logic            div_done;
    logic [QuoW-1:0] q_re;
    logic [QuoW-1:0] q_im;
    logic [DivW-1:0] n_re_mag;
    logic [DivW-1:0] n_im_mag;

    assign div_start = (state_reg == ST_NORM) && (phase_reg == PH_Q) && nrm_done && !nrm_zero;
    assign n_re_mag  = abs_re[DivW-1:0];
    assign n_im_mag  = abs_im[DivW-1:0];

    zpk_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n_re  (n_re_mag),
        .n_im  (n_im_mag),
        .d     (d_reg),
        .done  (div_done),
        .q_re  (q_re),
        .q_im  (q_im)
    );

    // Final scaling
    logic signed [ExpW-1:0] sh;
    scaled_t                sc_re;
    scaled_t                sc_im;

    assign sh    = nq_e_reg - ed_reg - ExpW'(16);
    assign sc_re = scale_part(nq_neg_re_reg, q_re, sh);
    assign sc_im = scale_part(nq_neg_im_reg, q_im, sh);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_re_reg    <= GainInit;
            gain_im_reg    <= '0;
            is_digital_reg <= 1'b1;
            zero_count_reg <= '0;
            pole_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_GAIN_RE:    gain_re_reg    <= cfg_wdata;
                CFG_GAIN_IM:    gain_im_reg    <= cfg_wdata;
                CFG_IS_DIGITAL: is_digital_reg <= cfg_wdata[0];
                CFG_ZERO_COUNT: zero_count_reg <= cfg_wdata[CntW-1:0];
                CFG_POLE_COUNT: pole_count_reg <= cfg_wdata[CntW-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NUM;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (mode == MODE_EVAL))
                    begin
                        if (is_digital_reg && (value_re == '0) && (value_im == '0))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_NUM;
                            step_reg  <= '0;
                            state_reg <= ST_ROOT;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (last_step)
                    begin
                        if (phase_reg == PH_NUM)
                        begin
                            phase_reg <= PH_GAIN;
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (use_store || use_point)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (nrm_done)
                    begin
                        unique case (phase_reg)
                            PH_NUM, PH_DEN:
                            begin
                                state_reg <= ST_ROOT;
                            end
                            PH_GAIN:
                            begin
                                phase_reg <= PH_DEN;
                                step_reg  <= '0;
                                state_reg <= ST_ROOT;
                            end
                            PH_D:
                            begin
                                phase_reg <= PH_Q;
                                state_reg <= ST_MUL;
                            end
                            PH_Q:
                            begin
                                if (nrm_zero)
                                begin
                                    done_reg  <= 1'b1;
                                    state_reg <= ST_IDLE;
                                end
                                else
                                begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    if (((den_re_reg == '0) && (den_im_reg == '0))
                        || ((num_re_reg == '0) && (num_im_reg == '0)))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        phase_reg <= PH_D;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_EVAL))
                begin
                    pt_re_reg        <= value_re;
                    pt_im_reg        <= value_im;
                    num_re_reg       <= MantInit;
                    num_im_reg       <= '0;
                    num_e_reg        <= ExpInit;
                    den_re_reg       <= MantInit;
                    den_im_reg       <= '0;
                    den_e_reg        <= ExpInit;
                    // Digital point at the origin: report the error now.
                    response_re_reg  <= '0;
                    response_im_reg  <= '0;
                    saturated_reg    <= 1'b0;
                    divide_error_reg <= 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (last_step)
                begin
                    fac_re_reg <= MantW'(gain_re_reg);
                    fac_im_reg <= MantW'(gain_im_reg);
                end
                else if (use_store)
                begin
                    fac_re_reg <= MantW'(DiffW'(pt_re_reg) - DiffW'(head.re));
                    fac_im_reg <= MantW'(DiffW'(pt_im_reg) - DiffW'(head.im));
                end
                else
                begin
                    fac_re_reg <= MantW'(pt_re_reg);
                    fac_im_reg <= MantW'(pt_im_reg);
                end
            end
            ST_MUL:
            begin
                prod_reg[0] <= a_re * b_re;
                prod_reg[1] <= a_im * b_im;
                prod_reg[2] <= a_re * b_im;
                prod_reg[3] <= a_im * b_re;
            end
            ST_SUM:
            begin
                unique case (phase_reg)
                    PH_Q:
                    begin
                        // num times conjugate of den
                        nrm_re_reg <= NormW'(prod_reg[0]) + NormW'(prod_reg[1]);
                        nrm_im_reg <= NormW'(prod_reg[3]) - NormW'(prod_reg[2]);
                        nrm_e_reg  <= num_e_reg + den_e_reg;
                    end
                    PH_D:
                    begin
                        // squared magnitude of den
                        nrm_re_reg <= NormW'(prod_reg[0]) + NormW'(prod_reg[1]);
                        nrm_im_reg <= '0;
                        nrm_e_reg  <= {den_e_reg[ExpW-2:0], 1'b0};
                    end
                    default:
                    begin
                        nrm_re_reg <= NormW'(prod_reg[0]) - NormW'(prod_reg[1]);
                        nrm_im_reg <= NormW'(prod_reg[2]) + NormW'(prod_reg[3]);
                        nrm_e_reg  <= a_e - ExpW'(FracBits);
                    end
                endcase
            end
            ST_NORM:
            begin
                if (nrm_done)
                begin
                    unique case (phase_reg)
                        PH_NUM, PH_GAIN:
                        begin
                            num_re_reg <= nrm_re_reg[MantW-1:0];
                            num_im_reg <= nrm_im_reg[MantW-1:0];
                            num_e_reg  <= nrm_zero ? '0 : nrm_e_reg;
                        end
                        PH_DEN:
                        begin
                            den_re_reg <= nrm_re_reg[MantW-1:0];
                            den_im_reg <= nrm_im_reg[MantW-1:0];
                            den_e_reg  <= nrm_zero ? '0 : nrm_e_reg;
                        end
                        PH_D:
                        begin
                            d_reg  <= nrm_re_reg[DivW-1:0];
                            ed_reg <= nrm_e_reg;
                        end
                        PH_Q:
                        begin
                            nq_neg_re_reg    <= nrm_re_reg < 0;
                            nq_neg_im_reg    <= nrm_im_reg < 0;
                            nq_e_reg         <= nrm_e_reg;
                            response_re_reg  <= '0;
                            response_im_reg  <= '0;
                            saturated_reg    <= 1'b0;
                            divide_error_reg <= 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (big4)
                begin
                    nrm_re_reg <= nrm_re_reg >>> 4;
                    nrm_im_reg <= nrm_im_reg >>> 4;
                    nrm_e_reg  <= nrm_e_reg + ExpW'(4);
                end
                else if (big1)
                begin
                    nrm_re_reg <= nrm_re_reg >>> 1;
                    nrm_im_reg <= nrm_im_reg >>> 1;
                    nrm_e_reg  <= nrm_e_reg + ExpW'(1);
                end
                else if (small4)
                begin
                    nrm_re_reg <= nrm_re_reg <<< 4;
                    nrm_im_reg <= nrm_im_reg <<< 4;
                    nrm_e_reg  <= nrm_e_reg - ExpW'(4);
                end
                else
                begin
                    nrm_re_reg <= nrm_re_reg <<< 1;
                    nrm_im_reg <= nrm_im_reg <<< 1;
                    nrm_e_reg  <= nrm_e_reg - ExpW'(1);
                end
            end
            ST_CHECK:
            begin
                // Zero denominator flags an error; zero numerator answers zero.
                response_re_reg  <= '0;
                response_im_reg  <= '0;
                saturated_reg    <= 1'b0;
                divide_error_reg <= (den_re_reg == '0) && (den_im_reg == '0);
            end
            ST_DIV:
            begin
            end
            ST_FIN:
            begin
                response_re_reg  <= sc_re.val;
                response_im_reg  <= sc_im.val;
                saturated_reg    <= sc_re.sat || sc_im.sat;
                divide_error_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign done         = done_reg;
    assign response_re  = response_re_reg;
    assign response_im  = response_im_reg;
    assign saturated    = saturated_reg;
    assign divide_error = divide_error_reg;

    `ZPK_ASSERT_NOW(a_err_zero, done && divide_error, (response_re == '0) && (response_im == '0) && !saturated, "divide error transfer carries a nonzero response")
    `ZPK_ASSERT_NOW(a_sat_no_err, done && saturated, !divide_error, "saturated and divide error both set")
    `ZPK_ASSERT_NOW(a_step_range, state_reg == ST_ROOT, step_reg <= StepW'(MaxOrder), "root step beyond store depth")
    `ZPK_ASSERT_NEXT(a_div_enter, div_start, state_reg == ST_DIV, "divider started outside divide state")
    `ZPK_ASSERT_NOW(a_div_done, div_done, state_reg == ST_DIV, "divider finished outside divide state")

endmodule

FILE: tb/zpk_transfer_function_eval_core_test.sv
module zpk_transfer_function_eval_core_test;
    import zpk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Widest legal wait between transfers before the run is declared hung.
    localparam int StallLimit = 20000;
    // Idle pause after the last response, before a register write.
    localparam int DrainCycles = 250;

    typedef struct packed {
        logic signed [OutW-1:0] re;
        logic signed [OutW-1:0] im;
        logic                   sat;
        logic                   div_err;
    } response_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             mode;
    logic [SlotW-1:0]       slot;
    logic signed [ValW-1:0] value_re;
    logic signed [ValW-1:0] value_im;
    logic                   cfg_we;
    logic [CfgIdxW-1:0]     cfg_addr;
    logic [ValW-1:0]        cfg_wdata;
    logic                   done;
    logic signed [OutW-1:0] response_re;
    logic signed [OutW-1:0] response_im;
    logic                   saturated;
    logic                   divide_error;

    zpk_transfer_function_eval_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .slot(slot), .value_re(value_re), .value_im(value_im),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .done(done), .response_re(response_re), .response_im(response_im),
        .saturated(saturated), .divide_error(divide_error)
    );

    // Shadow copy of the block's state and registers.
    longint    zero_re [MaxOrder];
    longint    zero_im [MaxOrder];
    longint    pole_re [MaxOrder];
    longint    pole_im [MaxOrder];
    longint    k_re;
    longint    k_im;
    bit        z_domain;
    int        n_zeros;
    int        n_poles;

    response_t pending_responses [$];
    int        mismatches;
    int        sender_gap_pct;
    int        stall_count;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Block floating point arithmetic of the evaluator
    // ---------------------------------------------------------------
    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    // Renormalize so the larger part magnitude lies in [2^29, 2^30).
    function automatic void renorm(inout longint re, inout longint im, inout int e);
        longint m;
        if (re == 0 && im == 0)
        begin
            e = 0;
            return;
        end
        m = mag(re) > mag(im) ? mag(re) : mag(im);
        while (m >= (64'sd1 << 30))
        begin
            re = re >>> 1;
            im = im >>> 1;
            e++;
            m = mag(re) > mag(im) ? mag(re) : mag(im);
        end
        while (m < (64'sd1 << 29))
        begin
            re = re * 2;
            im = im * 2;
            m = m * 2;
            e--;
        end
    endfunction

    function automatic void cmul(inout longint re, inout longint im, inout int e,
                                 input longint br, input longint bi);
        longint r;
        longint i;
        r = re * br - im * bi;
        i = re * bi + im * br;
        re = r;
        im = i;
        e = e - FracBits;
        renorm(re, im, e);
    endfunction

    // Divide one quotient part by |den|^2, scale to Q16.16 and clamp.
    function automatic logic [OutW-1:0] scale_to_q16(longint n, bit [63:0] d, int sh,
                                                     inout bit sat);
        bit        neg;
        bit [63:0] lim;
        bit [63:0] q;
        neg = n < 0;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        q = (64'(mag(n)) << 32) / d;
        if (sh < 0)
            q = (sh <= -64) ? 64'd0 : (q >> (-sh));
        else if (sh > 0)
        begin
            if (q != 0 && (sh >= 31 || q > (lim >> sh)))
            begin
                q = lim;
                sat = 1'b1;
            end
            else
                q = q << sh;
        end
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? OutW'(-q) : OutW'(q);
    endfunction

    // Expected response of one evaluate transfer at point (x, y).
    function automatic response_t evaluate_response(longint x, longint y);
        response_t r;
        int        nz;
        int        np;
        longint    nre, nim, dre, dim, qre, qim;
        int        ne, de, qe, ed, sh;
        bit [63:0] d;
        bit        sat;
        r = '{re: '0, im: '0, sat: 1'b0, div_err: 1'b1};
        sat = 1'b0;
        nz = n_zeros > MaxOrder ? MaxOrder : n_zeros;
        np = n_poles > MaxOrder ? MaxOrder : n_poles;
        if (z_domain && x == 0 && y == 0)
            return r;
        nre = 64'sd1 << 20;
        nim = 0;
        ne = -20;
        renorm(nre, nim, ne);
        dre = nre;
        dim = nim;
        de = ne;
        for (int i = 0; i < nz; i++)
            cmul(nre, nim, ne, x - zero_re[i], y - zero_im[i]);
        for (int i = 0; i < np; i++)
            cmul(dre, dim, de, x - pole_re[i], y - pole_im[i]);
        if (z_domain)
        begin
            // z^(np-nz) factor folded into whichever side is shorter
            for (int i = nz; i < np; i++)
                cmul(nre, nim, ne, x, y);
            for (int i = np; i < nz; i++)
                cmul(dre, dim, de, x, y);
        end
        cmul(nre, nim, ne, k_re, k_im);
        if (dre == 0 && dim == 0)
            return r;
        r.div_err = 1'b0;
        if (nre == 0 && nim == 0)
            return r;
        qre = nre * dre + nim * dim;
        qim = nim * dre - nre * dim;
        qe = ne + de;
        renorm(qre, qim, qe);
        d = 64'(mag(dre) * mag(dre)) + 64'(mag(dim) * mag(dim));
        ed = 2 * de;
        while (d >= (64'd1 << 30))
        begin
            d = d >> 1;
            ed++;
        end
        if (qre == 0 && qim == 0)
            return r;
        sh = qe - ed - 16;
        r.re = scale_to_q16(qre, d, sh, sat);
        r.im = scale_to_q16(qim, d, sh, sat);
        r.sat = sat;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Drive one item, hold it until the block takes it, then update the shadow.
    // Always entered and left just after a rising edge; start stays high.
    task automatic send_item(logic [1:0] m, int s, longint re, longint im);
        if ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        slot     <= SlotW'(s);
        value_re <= ValW'(re);
        value_im <= ValW'(im);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (m)
            MODE_LOAD_ZERO:
            begin
                zero_re[s] = re;
                zero_im[s] = im;
            end
            MODE_LOAD_POLE:
            begin
                pole_re[s] = re;
                pole_im[s] = im;
            end
            MODE_EVAL:
                pending_responses.push_back(evaluate_response(re, im));
            default: ;
        endcase
    endtask

    // Drop start, wait until every response is back, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_responses.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write one register; the caller has drained the block and drops cfg_we.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, longint v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= ValW'(v);
        @(posedge clk);
        case (idx)
            CFG_GAIN_RE:    k_re = longint'(signed'(ValW'(v)));
            CFG_GAIN_IM:    k_im = longint'(signed'(ValW'(v)));
            CFG_IS_DIGITAL: z_domain = v[0];
            CFG_ZERO_COUNT: n_zeros = int'(v[CntW-1:0]);
            CFG_POLE_COUNT: n_poles = int'(v[CntW-1:0]);
            default: ;
        endcase
    endtask

    task automatic write_all_regs(longint gr, longint gi, bit dig, int nz, int np);
        drain();
        write_reg(CFG_GAIN_RE, gr);
        write_reg(CFG_GAIN_IM, gi);
        write_reg(CFG_IS_DIGITAL, dig);
        write_reg(CFG_ZERO_COUNT, nz);
        write_reg(CFG_POLE_COUNT, np);
        cfg_we <= 1'b0;
    endtask

    // Mix of full range, unit scale, tiny and extreme Q4.20 values.
    function automatic longint pick_value();
        case ($urandom_range(5))
            0, 1:    return longint'(signed'(ValW'($urandom)));
            2:       return longint'($urandom_range(0, 4194304)) - 2097152;
            3:       return longint'($urandom_range(0, 64)) - 32;
            4:       return $urandom_range(1) ? 8388607 : -8388608;
            default: return 0;
        endcase
    endfunction

    function automatic longint pick_gain();
        case ($urandom_range(4))
            0:       return 8388607;
            1:       return -8388608;
            2:       return 0;
            3:       return longint'($urandom_range(0, 2097152)) - 1048576;
            default: return longint'(signed'(ValW'($urandom)));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill every zero and pole slot, extremes in the first two.
    task automatic test_fill_stores();
        send_item(MODE_LOAD_ZERO, 0, 8388607, 8388607);
        send_item(MODE_LOAD_ZERO, 1, -8388608, -8388608);
        send_item(MODE_LOAD_POLE, 0, -8388608, 8388607);
        send_item(MODE_LOAD_POLE, 1, 8388607, -8388608);
        for (int s = 2; s < MaxOrder; s++)
        begin
            send_item(MODE_LOAD_ZERO, s, 0, 0);
            send_item(MODE_LOAD_POLE, s, s * 524288, -262144);
        end
    endtask

    task automatic test_special_cases();
        // reset settings: digital, no roots, unit gain
        send_item(MODE_EVAL, 0, 0, 0);
        send_item(MODE_EVAL, 0, 8388607, -8388608);
        send_item(MODE_UNUSED, 5, 1048576, 1048576);

        // analog with all roots: hit a pole, hit a zero, plain point
        write_all_regs(1048576, 0, 1'b0, 8, 8);
        send_item(MODE_EVAL, 0, 3 * 524288, -262144);
        send_item(MODE_EVAL, 0, 8388607, 8388607);
        send_item(MODE_EVAL, 0, 1048576, 1048576);

        // count above depth, largest gain, far point: clamps
        write_all_regs(8388607, -8388608, 1'b0, 15, 0);
        send_item(MODE_EVAL, 0, 1048576, 8388607);
        send_item(MODE_EVAL, 0, -8388608, 0);

        // zero gain gives a zero numerator
        write_all_regs(0, 0, 1'b1, 3, 9);
        send_item(MODE_EVAL, 0, 1048576, 0);
    endtask

    task automatic test_random(int n_items, int gap_pct);
        longint re;
        longint im;
        int     s;
        int     pick;
        sender_gap_pct = gap_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 60 == 0)
                write_all_regs(pick_gain(), pick_gain(), $urandom_range(1),
                               $urandom_range(15), $urandom_range(15));
            if (i == n_items / 2)
                drain();
            s = $urandom_range(MaxOrder - 1);
            pick = $urandom_range(99);
            if (pick < 40)
                send_item(pick < 20 ? MODE_LOAD_ZERO : MODE_LOAD_POLE,
                          s, pick_value(), pick_value());
            else if (pick < 45)
                send_item(MODE_UNUSED, s, pick_value(), pick_value());
            else
            begin
                // sometimes right on a stored pole, sometimes near a stored zero, else random
                case ($urandom_range(3))
                    0:
                    begin
                        re = pole_re[s];
                        im = pole_im[s];
                    end
                    1:
                    begin
                        re = zero_re[s] + longint'($urandom_range(0, 512)) - 256;
                        im = zero_im[s] + longint'($urandom_range(0, 512)) - 256;
                    end
                    default:
                    begin
                        re = pick_value();
                        im = pick_value();
                    end
                endcase
                if (re > 8388607) re = 8388607;
                if (re < -8388608) re = -8388608;
                if (im > 8388607) im = 8388607;
                if (im < -8388608) im = -8388608;
                send_item(MODE_EVAL, 0, re, im);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Response check: the block cannot be stalled, sample on every done
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("unexpected response re=%0d im=%0d", response_re, response_im);
                mismatches++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (response_re !== want.re)
                begin
                    $error("response_re expected %0d got %0d", want.re, response_re);
                    mismatches++;
                end
                if (response_im !== want.im)
                begin
                    $error("response_im expected %0d got %0d", want.im, response_im);
                    mismatches++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated expected %0b got %0b", want.sat, saturated);
                    mismatches++;
                end
                if (divide_error !== want.div_err)
                begin
                    $error("divide_error expected %0b got %0b", want.div_err,
                           divide_error);
                    mismatches++;
                end
            end
        end
    end

    // Hang detector: count cycles with no transfer of any kind.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= StallLimit)
        begin
            $display("zpk_transfer_function_eval_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_LOAD_ZERO;
        slot = '0;
        value_re = '0;
        value_im = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_GAIN_RE;
        cfg_wdata = '0;
        mismatches = 0;
        stall_count = 0;
        sender_gap_pct = 0;
        foreach (zero_re[i])
        begin
            zero_re[i] = 0;
            zero_im[i] = 0;
            pole_re[i] = 0;
            pole_im[i] = 0;
        end
        k_re = 1048576;
        k_im = 0;
        z_domain = 1'b1;
        n_zeros = 0;
        n_poles = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_stores();
        test_special_cases();
        test_random(300, 22);
        test_random(300, 72);
        test_random(300, 0);

        drain();
        if (mismatches == 0)
            $display("zpk_transfer_function_eval_core_test: PASS");
        else
            $display("zpk_transfer_function_eval_core_test: FAIL");
        $finish;
    end

endmodule
